// ----- rtl/core/b2d_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII emitter.
`timescale 1ns / 1ps

package b2d_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;

    // Decimal digits needed for the widest VALUE_BITS value (floor(n*log10(2)) + 1).
    localparam int NUM_BCD_FULL = (VALUE_BITS * 30103) / 100000 + 1;
    // Digits actually kept: carries only move upward, so the low window is exact.
    localparam int BCD_DIGITS = (NUM_BCD_FULL < MAX_DIGITS) ? NUM_BCD_FULL : MAX_DIGITS;
    localparam int BCD_W = 4 * BCD_DIGITS;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(BCD_DIGITS + 1);

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_DIGIT_SHIFT
    } op_t;

    typedef struct packed {
        logic top_zero;
        logic overflow;
    } dp_status_t;

endpackage

// ----- rtl/core/b2d_shift_unit.sv -----
// Shared shift unit: add-3 and shift-in for conversion, digit shift for output.
`timescale 1ns / 1ps

module b2d_shift_unit (
    input  b2d_pkg::op_t                op,
    input  logic [b2d_pkg::BCD_W-1:0]   bcd_in,
    input  logic                        bin_bit,
    output logic [b2d_pkg::BCD_W-1:0]   bcd_out,
    output logic                        carry_out
);

    logic [b2d_pkg::BCD_W-1:0] adj;

    // Correct every digit of five or more before doubling.
    always_comb begin
        for (int i = 0; i < b2d_pkg::BCD_DIGITS; i++) begin
            if (bcd_in[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_in[4*i +: 4];
            end
        end
    end

    always_comb begin
        bcd_out   = bcd_in;
        carry_out = 1'b0;
        unique case (op)
            b2d_pkg::OP_HOLD: begin
                bcd_out = bcd_in;
            end
            b2d_pkg::OP_LOAD: begin
                bcd_out = '0;
            end
            b2d_pkg::OP_DABBLE: begin
                {carry_out, bcd_out} = {adj, bin_bit};
            end
            b2d_pkg::OP_DIGIT_SHIFT: begin
                bcd_out = {bcd_in[b2d_pkg::BCD_W-5:0], 4'b0000};
            end
            default: begin
                bcd_out = bcd_in;
            end
        endcase
    end

endmodule

// ----- rtl/core/b2d_datapath.sv -----
// Datapath registers: binary shift register, BCD digit register, overflow flag.
`timescale 1ns / 1ps

module b2d_datapath (
    input  logic                        aclk,
    input  b2d_pkg::op_t                op,
    input  logic [63:0]                 s_value,
    output logic [3:0]                  top_digit,
    output b2d_pkg::dp_status_t         status
);

    logic [b2d_pkg::VALUE_BITS-1:0] bin_reg, bin_next;
    logic [b2d_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic                           ovf_reg, ovf_next;
    logic                           carry;

    b2d_shift_unit u_shift (
        .op        (op),
        .bcd_in    (bcd_reg),
        .bin_bit   (bin_reg[b2d_pkg::VALUE_BITS-1]),
        .bcd_out   (bcd_next),
        .carry_out (carry)
    );

    always_comb begin
        bin_next = bin_reg;
        ovf_next = ovf_reg;
        unique case (op)
            b2d_pkg::OP_LOAD: begin
                bin_next = s_value[b2d_pkg::VALUE_BITS-1:0];
                ovf_next = 1'b0;
            end
            b2d_pkg::OP_DABBLE: begin
                bin_next = {bin_reg[b2d_pkg::VALUE_BITS-2:0], 1'b0};
                ovf_next = ovf_reg | carry;
            end
            default: begin
                bin_next = bin_reg;
                ovf_next = ovf_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        ovf_reg <= ovf_next;
    end

    assign top_digit       = bcd_reg[b2d_pkg::BCD_W-1 -: 4];
    assign status.top_zero = (top_digit == 4'd0);
    assign status.overflow = ovf_reg;

endmodule

// ----- rtl/core/b2d_seq.sv -----
// Sequencer: conversion bit count, leading-zero skip and digit emission.
`timescale 1ns / 1ps

module b2d_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        last,
    input  b2d_pkg::dp_status_t         status,
    output b2d_pkg::op_t                op
);

    b2d_pkg::state_t                state_reg, state_next;
    logic [b2d_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [b2d_pkg::DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic                           skip;

    // Drop a zero top digit unless it is the last one or higher digits were lost.
    assign skip = status.top_zero && (dig_cnt_reg > b2d_pkg::DIG_CNT_W'(1)) && !status.overflow;
    assign last = (dig_cnt_reg == b2d_pkg::DIG_CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            b2d_pkg::ST_IDLE: if (s_valid) state_next = b2d_pkg::ST_CONV;
            b2d_pkg::ST_CONV: if (bit_cnt_reg == b2d_pkg::BIT_CNT_W'(1)) begin
                state_next = b2d_pkg::ST_SKIP;
            end
            b2d_pkg::ST_SKIP: if (!skip) state_next = b2d_pkg::ST_EMIT;
            b2d_pkg::ST_EMIT: if (m_ready && last) state_next = b2d_pkg::ST_IDLE;
            default: state_next = b2d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        op      = b2d_pkg::OP_HOLD;
        unique case (state_reg)
            b2d_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                op      = s_valid ? b2d_pkg::OP_LOAD : b2d_pkg::OP_HOLD;
            end
            b2d_pkg::ST_CONV: begin
                op = b2d_pkg::OP_DABBLE;
            end
            b2d_pkg::ST_SKIP: begin
                op = skip ? b2d_pkg::OP_DIGIT_SHIFT : b2d_pkg::OP_HOLD;
            end
            b2d_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                op      = m_ready ? b2d_pkg::OP_DIGIT_SHIFT : b2d_pkg::OP_HOLD;
            end
            default: begin
                op = b2d_pkg::OP_HOLD;
            end
        endcase
    end

    always_comb begin
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        unique case (op)
            b2d_pkg::OP_LOAD: begin
                bit_cnt_next = b2d_pkg::BIT_CNT_W'(b2d_pkg::VALUE_BITS);
                dig_cnt_next = b2d_pkg::DIG_CNT_W'(b2d_pkg::BCD_DIGITS);
            end
            b2d_pkg::OP_DABBLE: begin
                bit_cnt_next = bit_cnt_reg - b2d_pkg::BIT_CNT_W'(1);
            end
            b2d_pkg::OP_DIGIT_SHIFT: begin
                dig_cnt_next = dig_cnt_reg - b2d_pkg::DIG_CNT_W'(1);
            end
            default: begin
                bit_cnt_next = bit_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= b2d_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

endmodule

// ----- rtl/core/binary_to_decimal_ascii_emitter_unit.sv -----
// Top level: converts a 64-bit unsigned value to decimal ASCII digits, MSD first.
// Sequence: an accept state loads the value, then a shift-add pass over all
//   VALUE_BITS (64) input bits and a leading-zero skip run before the first digit is offered.
// Throughput: a new input is accepted only after the last digit of the previous
//   one has been taken; the single shift-add unit and the digit shift register set this.
// Reset: aresetn (synchronous, active low) returns the sequencer to idle; data
//   registers are not reset.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_emitter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_digit_char,
    output logic        m_last_digit
);

    b2d_pkg::op_t        op;
    b2d_pkg::dp_status_t status;
    logic [3:0]          top_digit;
    logic                last;

    // Sequencer: accept a transaction, run the shift-add pass, skip leading
    // zeros, then hand out one digit per output transaction.
    b2d_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .last    (last),
        .status  (status),
        .op      (op)
    );

    // Datapath: binary and BCD registers around the shared shift unit.
    b2d_datapath u_dp (
        .aclk      (aclk),
        .op        (op),
        .s_value   (s_value),
        .top_digit (top_digit),
        .status    (status)
    );

    // Present the top BCD digit as ASCII; it holds while the sink stalls.
    assign m_digit_char = b2d_pkg::ASCII_ZERO + {2'b00, top_digit};
    assign m_last_digit = last;

endmodule
